// ===== rtl/core/swtm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtm_pkg
// Shared widths, op codes and cell control type for the traffic meter.
// ----------------------------------------------------------------------------
package swtm_pkg;

	localparam int WINDOW_TICKS = 16;
	localparam int IDX_W        = $clog2(WINDOW_TICKS);
	localparam int TIME_W       = 31;
	localparam int AMT_W        = 32;
	localparam int BUCKET_W     = 31;
	localparam int TOTAL_W      = 63;
	localparam int SUM_W        = BUCKET_W + $clog2(WINDOW_TICKS);

	localparam logic [BUCKET_W-1:0] BUCKET_MAX = {BUCKET_W{1'b1}};
	localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = {TOTAL_W{1'b1}};
	localparam logic [SUM_W-1:0]    WIN_DIV    = SUM_W'(WINDOW_TICKS);

	typedef enum logic [1:0] {
		OP_ADD     = 2'd0,
		OP_ADVANCE = 2'd1,
		OP_REPORT  = 2'd2
	} op_t;

	// per-item update applied to every cell in the same cycle
	typedef struct packed {
		logic                clear;
		logic                shift;
		logic                add;
		logic [BUCKET_W-1:0] amt;
	} cell_ctrl_t;

endpackage

// ===== rtl/core/swtm_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtm_req_if
// Request channel: op, tick time and amount with valid/ready.
// ----------------------------------------------------------------------------
interface swtm_req_if;
	import swtm_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        op;
	logic [TIME_W-1:0] tick_time;
	logic [AMT_W-1:0]  amount;

	modport source (output valid, output op, output tick_time, output amount, input ready);
	modport sink   (input valid, input op, input tick_time, input amount, output ready);

endinterface

// ===== rtl/core/swtm_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtm_res_if
// Result channel: window average and lifetime total with valid/ready.
// ----------------------------------------------------------------------------
interface swtm_res_if;
	import swtm_pkg::*;

	logic               valid;
	logic               ready;
	logic [TIME_W-1:0]  window_average;
	logic [TOTAL_W-1:0] lifetime_total;

	modport source (output valid, output window_average, output lifetime_total, input ready);
	modport sink   (input valid, input window_average, input lifetime_total, output ready);

endinterface

// ===== rtl/core/swtm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtm_cell
// One bucket of the window: clear, take neighbour on shift, saturating add.
// ----------------------------------------------------------------------------
module swtm_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  swtm_pkg::cell_ctrl_t          ctrl,
	input  logic                          sel,
	input  logic [swtm_pkg::BUCKET_W-1:0] next_in,
	output logic [swtm_pkg::BUCKET_W-1:0] bucket,
	output logic [swtm_pkg::BUCKET_W-1:0] delta
);
	import swtm_pkg::*;

	logic [BUCKET_W-1:0] bucket_q;
	logic [BUCKET_W-1:0] base_v;
	logic [BUCKET_W-1:0] headroom;

	always_comb begin
		if (ctrl.clear) begin
			base_v = '0;
		end else if (ctrl.shift) begin
			base_v = next_in;
		end else begin
			base_v = bucket_q;
		end
		headroom = BUCKET_MAX - base_v;
		if (ctrl.add && sel) begin
			delta = (ctrl.amt < headroom) ? ctrl.amt : headroom;
		end else begin
			delta = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_q <= '0;
		end else if (en) begin
			bucket_q <= base_v + delta;
		end
	end

	assign bucket = bucket_q;

endmodule

// ===== rtl/core/sliding_window_traffic_meter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_traffic_meter
// Per-tick traffic buckets over a sliding window with average and total.
// ----------------------------------------------------------------------------
// Each item passes a decode step that works out the window move
// (clear, shift by one or none) and the target bucket from the stored window
// start, then an update step in which the row of bucket cells applies it while the
// running bucket sum and the lifetime total follow, and the result then moves
// into the output register. A new item is taken once the previous result sits
// in the output register, so the meter never takes a new item before it is
// through with the last one. The buckets are cleared directly by reset; the average
// comes from the running sum, never from a pass over the buckets.
module sliding_window_traffic_meter (
	input  logic          clk,
	input  logic          arst_n,
	swtm_req_if.sink      req,
	swtm_res_if.source    res
);
	import swtm_pkg::*;

	logic                 s1_vld_s1;
	cell_ctrl_t           ctrl_s1;
	logic [WINDOW_TICKS-1:0] sel_s1;
	logic [TIME_W-1:0]    start_s1;

	logic [TIME_W-1:0]    start_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [SUM_W-1:0]     sum_q;
	logic                 pend_q;
	logic                 out_vld_q;
	logic [TIME_W-1:0]    out_avg_q;
	logic [TOTAL_W-1:0]   out_total_q;

	logic                 in_acc;
	logic                 is_add;
	logic                 is_adv;
	logic [TIME_W-1:0]    target;
	logic [TIME_W:0]      win_end;
	logic                 far;
	logic                 exact;
	logic                 do_clear;
	logic                 do_shift;
	logic [TIME_W-1:0]    new_start;
	logic [TIME_W-1:0]    idx_full;
	logic [IDX_W-1:0]     idx;

	logic [BUCKET_W-1:0]  bucket [WINDOW_TICKS];
	logic [BUCKET_W-1:0]  delta  [WINDOW_TICKS];
	logic [BUCKET_W-1:0]  delta_any;
	logic [SUM_W-1:0]     sum_base;
	logic [TOTAL_W:0]     total_sum;
	logic [SUM_W-1:0]     avg_full;
	logic                 out_load;

	assign req.ready = !s1_vld_s1 && !pend_q;
	assign in_acc    = req.valid && req.ready;

	// decode against the stored window start
	always_comb begin
		is_add = 1'b0;
		is_adv = 1'b0;
		case (op_t'(req.op))
			OP_ADD:     is_add = !req.amount[AMT_W-1];
			OP_ADVANCE: is_adv = 1'b1;
			OP_REPORT:  is_add = 1'b0;
			default:    is_add = 1'b0;
		endcase
		if (is_add || req.tick_time == '0) begin
			target = req.tick_time;
		end else begin
			target = req.tick_time - TIME_W'(1);
		end
		win_end   = {1'b0, start_q} + (TIME_W + 1)'(WINDOW_TICKS);
		far       = (win_end < {1'b0, target}) || (start_q > target);
		exact     = (win_end == {1'b0, target});
		do_clear  = (is_add || is_adv) && far;
		do_shift  = (is_add || is_adv) && exact;
		if (do_clear) begin
			new_start = target;
		end else if (do_shift) begin
			new_start = start_q + TIME_W'(1);
		end else begin
			new_start = start_q;
		end
		idx_full = target - new_start;
		idx      = idx_full[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_s1 <= 1'b0;
			ctrl_s1   <= '0;
		end else begin
			s1_vld_s1 <= in_acc;
			if (in_acc) begin
				ctrl_s1.clear <= do_clear;
				ctrl_s1.shift <= do_shift;
				ctrl_s1.add   <= is_add;
				ctrl_s1.amt   <= req.amount[BUCKET_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			start_s1 <= new_start;
			for (int i = 0; i < WINDOW_TICKS; i++) begin
				sel_s1[i] <= (idx == IDX_W'(i));
			end
		end
	end

	// row of bucket cells, each shifting towards index zero
	for (genvar g = 0; g < WINDOW_TICKS; g++) begin : g_cell
		logic [BUCKET_W-1:0] nbr;
		if (g == WINDOW_TICKS - 1) begin : g_last
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = bucket[g+1];
		end
		swtm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (s1_vld_s1),
			.ctrl    (ctrl_s1),
			.sel     (sel_s1[g]),
			.next_in (nbr),
			.bucket  (bucket[g]),
			.delta   (delta[g])
		);
	end

	always_comb begin
		delta_any = '0;
		for (int i = 0; i < WINDOW_TICKS; i++) begin
			delta_any = delta_any | delta[i];
		end
		if (ctrl_s1.clear) begin
			sum_base = '0;
		end else if (ctrl_s1.shift) begin
			sum_base = sum_q - SUM_W'(bucket[0]);
		end else begin
			sum_base = sum_q;
		end
		total_sum = {1'b0, total_q} + (TOTAL_W + 1)'(ctrl_s1.amt);
		avg_full  = sum_q / WIN_DIV;
		out_load  = pend_q && (!out_vld_q || res.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= '0;
			total_q   <= '0;
			sum_q     <= '0;
			pend_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (s1_vld_s1) begin
				start_q <= start_s1;
				sum_q   <= sum_base + SUM_W'(delta_any);
				if (ctrl_s1.add) begin
					total_q <= total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
				end
			end
			if (s1_vld_s1) begin
				pend_q <= 1'b1;
			end else if (out_load) begin
				pend_q <= 1'b0;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_avg_q   <= avg_full[TIME_W-1:0];
			out_total_q <= total_q;
		end
	end

	assign res.valid          = out_vld_q;
	assign res.window_average = out_avg_q;
	assign res.lifetime_total = out_total_q;

	// one item in flight at a time, carried through decode and update
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> s1_vld_s1 ##1 pend_q)
		else $error("item lost between decode and result");

	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		s1_vld_s1 |-> !(ctrl_s1.clear && ctrl_s1.shift))
		else $error("window cleared and shifted at once");

	a_shift: assert property (@(posedge clk) disable iff (!arst_n)
		s1_vld_s1 && ctrl_s1.shift |=> start_q == $past(start_q) + TIME_W'(1))
		else $error("window shift did not step the start by one");

	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		total_q >= $past(total_q))
		else $error("lifetime total went down");

endmodule
